FILE: rtl/lsq_pkg.sv
// ============================================================================
// lsq_pkg: shared constants for the parabola slope fitter
// Holds the multiplier chunk width and the stage count helpers used by the
// pipelined multipliers, the lanes and the top level.
// ============================================================================
package lsq_pkg;

  localparam int MUL_CHUNK = 32;

  function automatic int mul_stages(input int bw);
    return (bw + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

  // Stages of one multiplier: one per pair of operand chunks.
  function automatic int mul_lat(input int aw, input int bw);
    return mul_stages(aw) * mul_stages(bw);
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/lsq_parabola_slope_four_points.sv
// ============================================================================
// lsq_parabola_slope_four_points: least-squares parabola slope
// Fits a parabola to four points by least squares and returns its slope at
// the evaluation position, truncated toward zero and saturated.
// ============================================================================
//  channel  direction  handshake                 payload
//  in       request    in_valid_i / in_stall_o   pos_*_i, eval_pos_i, val_*_i
//  out      result     out_valid_o / out_stall_i slope_o, singular_o, saturated_o
//
//  One request enters per cycle unless in_stall_o is raised. L is the
//  number of chunk-pair stages along the three lane multiplier steps
//  (26 at the default width), and the quotient pipeline resolves one
//  bit per stage, DATA_WIDTH + 1 bits in all.
//  Reset clears only the valid line; no clearing pass is needed.
//  A result held by out_stall_i freezes the whole pipeline and raises
//  in_stall_o in the same cycle.
// ============================================================================
module lsq_parabola_slope_four_points #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] pos_one_i,
  input  logic signed [DATA_WIDTH-1:0] pos_two_i,
  input  logic signed [DATA_WIDTH-1:0] pos_three_i,
  input  logic signed [DATA_WIDTH-1:0] pos_four_i,
  input  logic signed [DATA_WIDTH-1:0] eval_pos_i,
  input  logic signed [DATA_WIDTH-1:0] val_one_i,
  input  logic signed [DATA_WIDTH-1:0] val_two_i,
  input  logic signed [DATA_WIDTH-1:0] val_three_i,
  input  logic signed [DATA_WIDTH-1:0] val_four_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] slope_o,
  output logic                         singular_o,
  output logic                         saturated_o
);
  import lsq_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int DX   = DW + 1;
  localparam int SQW  = 2 * DX;
  localparam int SD   = SQW + 1;
  localparam int PW   = DW + SD + 2;
  localparam int DDW  = 3 * DX;
  localparam int DDO  = 2 * DDW;
  localparam int DPO  = PW + DDW;
  localparam int DENW = DDO + 2;
  localparam int NUMW = DPO + 2;
  localparam int L1   = max_int(mul_lat(DX, DX), mul_lat(SD, DW));
  localparam int L2   = mul_lat(2 * DX, DX);
  localparam int L3   = max_int(mul_lat(DDW, DDW), mul_lat(PW, DDW));
  localparam int LAT  = 7 + DW + L1 + L2 + L3;
  localparam int TI [4] = '{0, 0, 0, 1};
  localparam int TJ [4] = '{1, 1, 2, 2};
  localparam int TK [4] = '{2, 3, 3, 3};

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [DW-1:0] x_in [4];
  logic signed [DW-1:0] f_in [4];

  assign x_in[0] = pos_one_i;
  assign x_in[1] = pos_two_i;
  assign x_in[2] = pos_three_i;
  assign x_in[3] = pos_four_i;
  assign f_in[0] = val_one_i;
  assign f_in[1] = val_two_i;
  assign f_in[2] = val_three_i;
  assign f_in[3] = val_four_i;

  logic signed [DX-1:0]  u_q  [4];
  logic signed [DW-1:0]  x_q  [4];
  logic signed [DW-1:0]  f_q  [4];
  logic signed [SQW-1:0] sq_q [4];
  logic signed [DW-1:0]  x2_q [4];
  logic signed [DW-1:0]  f2_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        u_q[t]  <= DX'(x_in[t]) - DX'(eval_pos_i);
        x_q[t]  <= x_in[t];
        f_q[t]  <= f_in[t];
        sq_q[t] <= u_q[t] * u_q[t];
        x2_q[t] <= x_q[t];
        f2_q[t] <= f_q[t];
      end
    end
  end

  logic [DDO-1:0] dd [4];
  logic [DPO-1:0] dp [4];

  for (genvar t = 0; t < 4; t++) begin : g_lane
    lsq_lane #(.DW(DW)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .xi_i  (x2_q[TI[t]]),
      .xj_i  (x2_q[TJ[t]]),
      .xk_i  (x2_q[TK[t]]),
      .fi_i  (f2_q[TI[t]]),
      .fj_i  (f2_q[TJ[t]]),
      .fk_i  (f2_q[TK[t]]),
      .sqi_i (sq_q[TI[t]]),
      .sqj_i (sq_q[TJ[t]]),
      .sqk_i (sq_q[TK[t]]),
      .dd_o  (dd[t]),
      .dp_o  (dp[t])
    );
  end

  logic signed [DENW-1:0] den_q;
  logic signed [NUMW-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= DENW'($signed(dd[0])) + DENW'($signed(dd[1]))
             + DENW'($signed(dd[2])) + DENW'($signed(dd[3]));
      num_q <= NUMW'($signed(dp[0])) + NUMW'($signed(dp[1]))
             + NUMW'($signed(dp[2])) + NUMW'($signed(dp[3]));
    end
  end

  lsq_div #(.DW(DW), .FRAC(FRAC_BITS), .NUMW(NUMW), .DENW(DENW)) u_div (
    .clk_i       (clk_i),
    .en_i        (en),
    .num_i       (num_q),
    .den_i       (den_q),
    .slope_o     (slope_o),
    .singular_o  (singular_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: rtl/lsq_dly.sv
// ============================================================================
// lsq_dly: enabled delay line
// Delays a word through DEPTH registers that advance only when enabled.
// ============================================================================
module lsq_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (DEPTH == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] sr_q [DEPTH];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[0] <= d_i;
        for (int i = 1; i < DEPTH; i++) begin
          sr_q[i] <= sr_q[i-1];
        end
      end
    end

    assign q_o = sr_q[DEPTH-1];
  end

endmodule

FILE: rtl/lsq_mul.sv
// ============================================================================
// lsq_mul: pipelined signed multiplier
// Multiplies two signed words, one pair of 32-bit operand chunks per stage,
// and pads the result through a delay line to LAT stages in all.
// ============================================================================
module lsq_mul #(
  parameter int AW  = 33,
  parameter int BW  = 33,
  parameter int LAT = 4
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic [AW+BW-1:0]     p_o
);
  import lsq_pkg::*;

  localparam int NA = mul_stages(AW);
  localparam int NB = mul_stages(BW);
  localparam int NS = NA * NB;
  localparam int XA = NA * MUL_CHUNK;
  localparam int XB = NB * MUL_CHUNK;
  localparam int PX = XA + XB;

  logic [XA-1:0] a_q   [NS];
  logic [XB-1:0] b_q   [NS];
  logic [PX-1:0] acc_q [NS];
  logic [XA-1:0] ax;
  logic [XB-1:0] bx;

  assign ax = XA'(a_i);
  assign bx = XB'(b_i);

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int M = s % NA;
    localparam int K = s / NA;

    logic [XA-1:0]                 a_in;
    logic [XB-1:0]                 b_in;
    logic [PX-1:0]                 acc_in;
    logic signed [MUL_CHUNK:0]     ca;
    logic signed [MUL_CHUNK:0]     cb;
    logic signed [2*MUL_CHUNK+1:0] pp;

    if (s == 0) begin : g_first
      assign a_in   = ax;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    if (M == NA - 1) begin : g_atop
      assign ca = {a_in[M*MUL_CHUNK+MUL_CHUNK-1], a_in[M*MUL_CHUNK +: MUL_CHUNK]};
    end else begin : g_alow
      assign ca = {1'b0, a_in[M*MUL_CHUNK +: MUL_CHUNK]};
    end

    if (K == NB - 1) begin : g_btop
      assign cb = {b_in[K*MUL_CHUNK+MUL_CHUNK-1], b_in[K*MUL_CHUNK +: MUL_CHUNK]};
    end else begin : g_blow
      assign cb = {1'b0, b_in[K*MUL_CHUNK +: MUL_CHUNK]};
    end

    assign pp = ca * cb;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_in + (PX'(pp) << ((M + K) * MUL_CHUNK));
      end
    end
  end

  lsq_dly #(.W(AW + BW), .DEPTH(LAT - NS)) u_pad (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (acc_q[NS-1][AW+BW-1:0]),
    .q_o   (p_o)
  );

endmodule

FILE: rtl/lsq_lane.sv
// ============================================================================
// lsq_lane: one point triple of the normal determinant expansion
// Computes the Vandermonde product d and the weighted square differences p
// for one triple, and returns d*d and d*p.
// ============================================================================
module lsq_lane #(
  parameter int DW = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DW-1:0]        xi_i,
  input  logic signed [DW-1:0]        xj_i,
  input  logic signed [DW-1:0]        xk_i,
  input  logic signed [DW-1:0]        fi_i,
  input  logic signed [DW-1:0]        fj_i,
  input  logic signed [DW-1:0]        fk_i,
  input  logic signed [2*DW+1:0]      sqi_i,
  input  logic signed [2*DW+1:0]      sqj_i,
  input  logic signed [2*DW+1:0]      sqk_i,
  output logic [6*DW+5:0]             dd_o,
  output logic [6*DW+7:0]             dp_o
);
  import lsq_pkg::*;

  localparam int DX  = DW + 1;
  localparam int SQW = 2 * DX;
  localparam int SD  = SQW + 1;
  localparam int PW  = DW + SD + 2;
  localparam int DDW = 3 * DX;
  localparam int L1  = max_int(mul_lat(DX, DX), mul_lat(SD, DW));
  localparam int L2  = mul_lat(2 * DX, DX);
  localparam int L3  = max_int(mul_lat(DDW, DDW), mul_lat(PW, DDW));

  logic signed [DX-1:0] e1_q, e2_q, e3_q;
  logic signed [SD-1:0] s1_q, s2_q, s3_q;
  logic signed [DW-1:0] fi_q, fj_q, fk_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q <= DX'(xj_i) - DX'(xi_i);
      e2_q <= DX'(xk_i) - DX'(xi_i);
      e3_q <= DX'(xk_i) - DX'(xj_i);
      s1_q <= SD'(sqj_i) - SD'(sqk_i);
      s2_q <= SD'(sqk_i) - SD'(sqi_i);
      s3_q <= SD'(sqi_i) - SD'(sqj_i);
      fi_q <= fi_i;
      fj_q <= fj_i;
      fk_q <= fk_i;
    end
  end

  logic [2*DX-1:0]    m12;
  logic [SD+DW-1:0]   p1, p2, p3;
  logic [DX-1:0]      e3_d;

  lsq_mul #(.AW(DX), .BW(DX), .LAT(L1)) u_m12 (
    .clk_i(clk_i), .en_i(en_i), .a_i(e1_q), .b_i(e2_q), .p_o(m12));
  lsq_mul #(.AW(SD), .BW(DW), .LAT(L1)) u_p1 (
    .clk_i(clk_i), .en_i(en_i), .a_i(s1_q), .b_i(fi_q), .p_o(p1));
  lsq_mul #(.AW(SD), .BW(DW), .LAT(L1)) u_p2 (
    .clk_i(clk_i), .en_i(en_i), .a_i(s2_q), .b_i(fj_q), .p_o(p2));
  lsq_mul #(.AW(SD), .BW(DW), .LAT(L1)) u_p3 (
    .clk_i(clk_i), .en_i(en_i), .a_i(s3_q), .b_i(fk_q), .p_o(p3));
  lsq_dly #(.W(DX), .DEPTH(L1)) u_e3 (
    .clk_i(clk_i), .en_i(en_i), .d_i(e3_q), .q_o(e3_d));

  logic signed [PW-1:0] psum;
  logic [PW-1:0]        p_d;
  logic [DDW-1:0]       d_v;

  assign psum = PW'($signed(p1)) + PW'($signed(p2)) + PW'($signed(p3));

  lsq_dly #(.W(PW), .DEPTH(L2)) u_pd (
    .clk_i(clk_i), .en_i(en_i), .d_i(psum), .q_o(p_d));
  lsq_mul #(.AW(2 * DX), .BW(DX), .LAT(L2)) u_d (
    .clk_i(clk_i), .en_i(en_i), .a_i($signed(m12)), .b_i($signed(e3_d)), .p_o(d_v));

  lsq_mul #(.AW(DDW), .BW(DDW), .LAT(L3)) u_dd (
    .clk_i(clk_i), .en_i(en_i), .a_i($signed(d_v)), .b_i($signed(d_v)), .p_o(dd_o));
  lsq_mul #(.AW(PW), .BW(DDW), .LAT(L3)) u_dp (
    .clk_i(clk_i), .en_i(en_i), .a_i($signed(p_d)), .b_i($signed(d_v)), .p_o(dp_o));

endmodule

FILE: rtl/lsq_div.sv
// ============================================================================
// lsq_div: pipelined slope quotient
// Divides the fitted numerator by the determinant one quotient bit per
// stage, then truncates toward zero, saturates and flags singular fits.
// ============================================================================
module lsq_div #(
  parameter int DW   = 32,
  parameter int FRAC = 16,
  parameter int NUMW = 202,
  parameter int DENW = 200
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic signed [DENW-1:0] den_i,
  output logic signed [DW-1:0]   slope_o,
  output logic                   singular_o,
  output logic                   saturated_o
);

  localparam int RW = (NUMW + FRAC > DENW + DW + 1) ? NUMW + FRAC : DENW + DW + 1;
  localparam logic [DW:0] LIM = (DW + 1)'(1) << (DW - 1);
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW - 1){1'b0}}};

  logic            neg;
  logic [NUMW-1:0] mag;
  logic [RW-1:0]   a0, b0;

  assign neg = num_i[NUMW-1];
  assign mag = neg ? NUMW'(-num_i) : NUMW'(num_i);
  assign a0  = RW'(mag) << FRAC;
  assign b0  = RW'($unsigned(den_i));

  logic [RW-1:0] rem_q  [DW+1];
  logic [RW-1:0] b_q    [DW+1];
  logic [DW:0]   q_q    [DW+2];
  logic          neg_q  [DW+2];
  logic          sing_q [DW+2];
  logic          ovf_q  [DW+2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= a0;
      b_q[0]    <= b0;
      q_q[0]    <= '0;
      neg_q[0]  <= neg;
      sing_q[0] <= (den_i == '0);
      ovf_q[0]  <= (a0 >= (b0 << (DW + 1)));
    end
  end

  for (genvar k = 0; k <= DW; k++) begin : g_bit
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = b_q[k] << (DW - k);
    assign ge = rem_q[k] >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]    <= q_q[k] | ((DW + 1)'(ge) << (DW - k));
        neg_q[k+1]  <= neg_q[k];
        sing_q[k+1] <= sing_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end

    if (k < DW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? rem_q[k] - sh : rem_q[k];
          b_q[k+1]   <= b_q[k];
        end
      end
    end
  end

  logic [DW:0]   qf;
  logic          nf, sf, of, clip;
  logic [DW-1:0] slope_d;

  assign qf   = q_q[DW+1];
  assign nf   = neg_q[DW+1];
  assign sf   = sing_q[DW+1];
  assign of   = ovf_q[DW+1];
  assign clip = of || (nf ? (qf > LIM) : (qf >= LIM));

  always_comb begin
    if (sf) begin
      slope_d = '0;
    end else if (clip) begin
      slope_d = nf ? SMIN : SMAX;
    end else if (nf) begin
      slope_d = DW'(-qf);
    end else begin
      slope_d = qf[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slope_o     <= slope_d;
      singular_o  <= sf;
      saturated_o <= !sf && clip;
    end
  end

endmodule

FILE: rtl/lsq_chk.sv
// ============================================================================
// lsq_chk: port checker for the parabola slope fitter
// Watches the top-level ports and checks flow control and result flags.
// ============================================================================
module lsq_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [DATA_WIDTH-1:0] slope_o,
  input logic                         singular_o,
  input logic                         saturated_o
);

  localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slope_o)
      && $stable(singular_o) && $stable(saturated_o))
    else $error("held result changed");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a blocked result");

  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> slope_o == '0 && !saturated_o)
    else $error("singular result is not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> slope_o == SMAX || slope_o == SMIN)
    else $error("saturated result is not a range limit");

endmodule

bind lsq_parabola_slope_four_points lsq_chk #(.DATA_WIDTH(DATA_WIDTH)) u_lsq_chk (.*);
